@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

  // Field widths and internal datapath widths.
  localparam int CoefW        = 16;
  localparam int RootFracBits = 16;
  localparam int DiscW        = 34;
  localparam int RootW        = DiscW / 2;
  localparam int SremW        = RootW + 2;
  localparam int NumW         = 19;
  localparam int DenW         = 18;
  localparam int QuoW         = NumW + RootFracBits;
  localparam int OutW         = 40;
  localparam int ExtW         = (QuoW + 2 > OutW + 1) ? QuoW + 2 : OutW + 1;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_DISTINCT = 2'd1,
    KIND_REPEAT   = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_e;

  // Everything one coefficient set carries along the cell chain.
  typedef struct packed {
    logic signed [CoefW-1:0]     a;
    logic signed [CoefW-1:0]     b;
    logic signed [2*CoefW-1:0]   bb;
    logic signed [2*CoefW-1:0]   ac;
    root_kind_e                  kind;
    logic [DiscW-1:0]            v;
    logic [SremW-1:0]            srem;
    logic [RootW-1:0]            root;
    logic [1:0]                  qneg;
    logic [1:0][QuoW-1:0]        nmag;
    logic [1:0][DenW-1:0]        dmag;
    logic [1:0][DenW-1:0]        drem;
    logic [1:0][QuoW-1:0]        quo;
  } item_t;

endpackage

@@ hw/rtl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic                 valid_q;
  item_t                item_q;
  item_t                item_d;
  logic [SremW+1:0]     pre;
  logic [SremW+1:0]     trial;

  // One result bit of the floored square root: bring down two radicand bits.
  always_comb begin
    item_d = item_i;
    pre    = {item_i.srem, item_i.v[DiscW-1 -: 2]};
    trial  = (SremW+2)'({item_i.root, 2'b01});
    if (pre >= trial) begin
      item_d.srem = SremW'(pre - trial);
      item_d.root = {item_i.root[RootW-2:0], 1'b1};
    end else begin
      item_d.srem = SremW'(pre);
      item_d.root = {item_i.root[RootW-2:0], 1'b0};
    end
    item_d.v = {item_i.v[DiscW-3:0], 2'b00};
  end

  // The cell takes a beat whenever it is empty or its neighbor takes its beat.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/qrs_div_cell.sv @@
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic            valid_q;
  item_t           item_q;
  item_t           item_d;
  logic [DenW:0]   pre [2];

  // One quotient bit for each of the two restoring dividers.
  always_comb begin
    item_d = item_i;
    for (int j = 0; j < 2; j++) begin
      pre[j] = {item_i.drem[j], item_i.nmag[j][QuoW-1]};
      if (pre[j] >= (DenW+1)'(item_i.dmag[j])) begin
        item_d.drem[j] = DenW'(pre[j] - (DenW+1)'(item_i.dmag[j]));
        item_d.quo[j]  = {item_i.quo[j][QuoW-2:0], 1'b1};
      end else begin
        item_d.drem[j] = DenW'(pre[j]);
        item_d.quo[j]  = {item_i.quo[j][QuoW-2:0], 1'b0};
      end
      item_d.nmag[j] = {item_i.nmag[j][QuoW-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/quadratic_root_solver.sv @@
// Channel     Dir  Fields (tdata / tuser, lowest bit first)
// s_axis      in   tdata: coef_a[15:0], coef_b[31:16], coef_c[47:32]
// m_axis      out  tdata: first_value[39:0], second_value[79:40];
//                  tuser: root_kind[1:0], saturated[2]
//
// One beat is accepted every cycle unless the chain is stalled; the path from input beat
// to result beat runs through two product/discriminant stages, 17 square-root cells,
// one numerator stage, 35 divider cells and the output register.
// Every stage holds its own valid bit, so bubbles close up and a new beat is
// taken while a finished result waits, as long as some stage is empty.
// Reset clears only the valid bits; no clearing pass is needed.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [47:0]  s_axis_tdata_i,   // coef_a, coef_b, coef_c
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [79:0]  m_axis_tdata_o,   // first_value, second_value
  output logic [2:0]   m_axis_tuser_o    // root_kind, saturated
);

  localparam int StSq0  = 2;
  localparam int StPrep = StSq0 + RootW;
  localparam int StDv0  = StPrep + 1;
  localparam int StOut  = StDv0 + QuoW;
  localparam int NStg   = StOut + 1;

  localparam logic signed [ExtW-1:0] OutMaxX = ExtW'({1'b0, {(OutW-1){1'b1}}});
  localparam logic signed [ExtW-1:0] OutMinX = -OutMaxX - ExtW'(1);

  logic [NStg-1:0] vld;
  logic [NStg-1:0] rdy;
  item_t           itm [StOut];

  item_t           front_d, disc_d, prep_d;
  item_t           front_q, disc_q, prep_q;
  logic            front_vq, disc_vq, prep_vq, out_vq;

  // Front stage: both 16x16 products.
  always_comb begin
    front_d    = '0;
    front_d.a  = s_axis_tdata_i[15:0];
    front_d.b  = s_axis_tdata_i[31:16];
    front_d.bb = front_d.b * front_d.b;
    front_d.ac = front_d.a * $signed(s_axis_tdata_i[47:32]);
  end

  assign rdy[0] = !front_vq || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vq <= 1'b0;
    end else if (rdy[0]) begin
      front_vq <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid_i) begin
      front_q <= front_d;
    end
  end

  assign vld[0] = front_vq;
  assign itm[0] = front_q;

  // Discriminant stage: exact b*b - 4ac, kind and radicand magnitude.
  logic signed [DiscW-1:0] disc;

  always_comb begin
    disc_d      = itm[0];
    disc        = DiscW'(itm[0].bb) - (DiscW'(itm[0].ac) <<< 2);
    disc_d.srem = '0;
    disc_d.root = '0;
    disc_d.v    = disc[DiscW-1] ? DiscW'(-disc) : DiscW'(disc);
    if (itm[0].a == '0) begin
      disc_d.kind = KIND_NONE;
    end else if (disc[DiscW-1]) begin
      disc_d.kind = KIND_COMPLEX;
    end else if (disc == '0) begin
      disc_d.kind = KIND_REPEAT;
    end else begin
      disc_d.kind = KIND_DISTINCT;
    end
  end

  assign rdy[1] = !disc_vq || rdy[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_vq <= 1'b0;
    end else if (rdy[1]) begin
      disc_vq <= vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld[0]) begin
      disc_q <= disc_d;
    end
  end

  assign vld[1] = disc_vq;
  assign itm[1] = disc_q;

  // Square-root cells, one result bit each.
  for (genvar k = StSq0; k < StPrep; k++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k-1]),
      .ready_o (rdy[k]),
      .item_i  (itm[k-1]),
      .valid_o (vld[k]),
      .ready_i (rdy[k+1]),
      .item_o  (itm[k])
    );
  end

  // Numerator stage: pick numerators and divisors, split off the signs.
  logic signed [NumW-1:0] nb, sq, num [2];
  logic signed [DenW-1:0] den, dv [2];
  logic [NumW-1:0]        nabs [2];

  always_comb begin
    prep_d = itm[StPrep-1];
    nb     = -NumW'(itm[StPrep-1].b);
    sq     = NumW'(itm[StPrep-1].root);
    den    = DenW'(itm[StPrep-1].a) <<< 1;
    num[0] = nb;
    num[1] = nb;
    dv[0]  = den;
    dv[1]  = den;
    case (itm[StPrep-1].kind)
      KIND_DISTINCT: begin
        num[0] = nb + sq;
        num[1] = nb - sq;
      end
      KIND_COMPLEX: begin
        num[1] = sq;
        dv[1]  = den[DenW-1] ? -den : den;
      end
      default: begin
        num[1] = nb;
      end
    endcase
    for (int j = 0; j < 2; j++) begin
      nabs[j]           = num[j][NumW-1] ? NumW'(-num[j]) : NumW'(num[j]);
      prep_d.qneg[j]    = num[j][NumW-1] ^ dv[j][DenW-1];
      prep_d.nmag[j]    = QuoW'(nabs[j]) << RootFracBits;
      prep_d.dmag[j]    = dv[j][DenW-1] ? DenW'(-dv[j]) : DenW'(dv[j]);
      prep_d.drem[j]    = '0;
      prep_d.quo[j]     = '0;
    end
  end

  assign rdy[StPrep] = !prep_vq || rdy[StPrep+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vq <= 1'b0;
    end else if (rdy[StPrep]) begin
      prep_vq <= vld[StPrep-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StPrep] && vld[StPrep-1]) begin
      prep_q <= prep_d;
    end
  end

  assign vld[StPrep] = prep_vq;
  assign itm[StPrep] = prep_q;

  // Divider cells, one quotient bit of both lanes each.
  for (genvar k = StDv0; k < StOut; k++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k-1]),
      .ready_o (rdy[k]),
      .item_i  (itm[k-1]),
      .valid_o (vld[k]),
      .ready_i (rdy[k+1]),
      .item_o  (itm[k])
    );
  end

  // Output stage: restore signs, saturate, zero the not-quadratic case.
  logic signed [ExtW-1:0] qs [2];
  logic [1:0][OutW-1:0]   val;
  logic [1:0]             clip;
  logic [79:0]            tdata_d, tdata_q;
  logic [2:0]             tuser_d, tuser_q;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qs[j] = $signed(ExtW'(itm[StOut-1].quo[j]));
      if (itm[StOut-1].qneg[j]) begin
        qs[j] = -qs[j];
      end
      clip[j] = 1'b0;
      val[j]  = OutW'(qs[j]);
      if (qs[j] > OutMaxX) begin
        clip[j] = 1'b1;
        val[j]  = OutW'(OutMaxX);
      end else if (qs[j] < OutMinX) begin
        clip[j] = 1'b1;
        val[j]  = OutW'(OutMinX);
      end
    end
    if (itm[StOut-1].kind == KIND_NONE) begin
      tdata_d = '0;
      tuser_d = {1'b0, KIND_NONE};
    end else begin
      tdata_d = {val[1], val[0]};
      tuser_d = {|clip, itm[StOut-1].kind};
    end
  end

  assign rdy[StOut] = !out_vq || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (rdy[StOut]) begin
      out_vq <= vld[StOut-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut] && vld[StOut-1]) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign vld[StOut]      = out_vq;
  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

  // A stalled input means every stage up to the output is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while the chain has room");

  // The not-quadratic case carries all-zero values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == KIND_NONE |->
      m_axis_tdata_o == '0 && !m_axis_tuser_o[2])
    else $error("not-quadratic result with nonzero values");

  // A repeated root gives the same value twice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == KIND_REPEAT |->
      m_axis_tdata_o[39:0] == m_axis_tdata_o[79:40])
    else $error("repeated root with differing values");

  // The imaginary magnitude of a complex pair is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] == KIND_COMPLEX |-> !m_axis_tdata_o[79])
    else $error("negative imaginary magnitude");

endmodule
